[rtl/bta_pkg.sv]
// Shared types and constants for the bakery ticket arbiter.
// Used by bta_cell, bakery_ticket_arbiter and the testbench; depends on nothing.
package bta_pkg;

	localparam int NUM_CLIENTS  = 8;
	localparam int TICKET_BITS  = 16;
	localparam int IDX_BITS     = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
	localparam int CNT_BITS     = $clog2(NUM_CLIENTS + 1);
	localparam int CFG_BITS     = 4;
	localparam int CLIENT_W     = 3;
	localparam int ASSIGNED_W   = 16;
	localparam int STATUS_W     = 2;
	localparam int OUT_W        = 1 + CLIENT_W + ASSIGNED_W + STATUS_W;
	localparam int OUT_BYTES_W  = ((OUT_W + 7) / 8) * 8;
	localparam int IN_BYTES_W   = ((CLIENT_W + 7) / 8) * 8;

	localparam logic [TICKET_BITS-1:0] TICKET_MAX = {TICKET_BITS{1'b1}};

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_REDUNDANT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NO_TICKET = 2'd2;
	localparam logic [STATUS_W-1:0] ST_SATURATED = 2'd3;

	localparam logic ACT_REQUEST = 1'b0;
	localparam logic ACT_RELEASE = 1'b1;

	// Record that walks down the chain of cells during one scan.
	typedef struct packed {
		logic                   vld;
		logic [CLIENT_W-1:0]    client;
		logic [TICKET_BITS-1:0] top;
		logic                   best_vld;
		logic [TICKET_BITS-1:0] best_t;
		logic [IDX_BITS-1:0]    best_idx;
		logic [TICKET_BITS-1:0] own_t;
	} scan_t;

	// Ticket write broadcast to all cells at the end of a scan.
	typedef struct packed {
		logic                   en;
		logic [IDX_BITS-1:0]    idx;
		logic [TICKET_BITS-1:0] value;
	} wr_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

endpackage

[rtl/bta_cell.sv]
// One cell of the ticket chain: holds one client's ticket and folds it into
// the scan record handed on from its left neighbor. Depends on bta_pkg.
module bta_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [bta_pkg::IDX_BITS-1:0]  idx,
	input  logic [bta_pkg::CNT_BITS-1:0]  count,
	input  bta_pkg::scan_t                rin,
	input  bta_pkg::wr_t                  wr,
	output bta_pkg::scan_t                rout
);
	import bta_pkg::*;

	logic [TICKET_BITS-1:0] ticket_q;
	logic                   part;
	logic                   is_cli;
	scan_t                  nxt;
	scan_t                  rout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticket_q <= '0;
		end else if (wr.en && wr.idx == idx) begin
			ticket_q <= wr.value;
		end
	end

	always_comb begin
		part   = 32'(idx) < 32'(count);
		is_cli = 32'(rin.client) == 32'(idx);
		nxt    = rin;
		if (part) begin
			if (ticket_q > rin.top) begin
				nxt.top = ticket_q;
			end
			// The issuing client is left out of the grant search here; its new
			// ticket is weighed once the record reaches the controller.
			if (is_cli) begin
				nxt.own_t = ticket_q;
			end else if (ticket_q != '0 && (!rin.best_vld || ticket_q < rin.best_t)) begin
				nxt.best_vld = 1'b1;
				nxt.best_t   = ticket_q;
				nxt.best_idx = idx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rout_q <= '0;
		end else begin
			rout_q.vld <= rin.vld;
			if (rin.vld) begin
				rout_q.client   <= nxt.client;
				rout_q.top      <= nxt.top;
				rout_q.best_vld <= nxt.best_vld;
				rout_q.best_t   <= nxt.best_t;
				rout_q.best_idx <= nxt.best_idx;
				rout_q.own_t    <= nxt.own_t;
			end
		end
	end

	assign rout = rout_q;

endmodule

[rtl/bakery_ticket_arbiter.sv]
// Top level of the bakery ticket arbiter: stream ports, control sequencer
// and the chain of bta_cell ticket cells. Depends on bta_pkg and bta_cell.
//
//  channel  | signals                          | carries
//  ---------+----------------------------------+-------------------------------
//  s_       | s_tvalid s_tready s_tdata s_tuser | one lock event per transfer
//  m_       | m_tvalid m_tready m_tdata        | grant and status per event
//  cfg_     | cfg_we cfg_wdata                 | active_clients register
//
// For each event the scan record steps through one cell per cycle, then the
// done state writes the ticket back and loads the result once that register is free.
// A new event is taken only while the sequencer is idle; the result register
// lets the next event start while a result still waits on m_tready.
// Reset clears all tickets at once and sets active_clients to 8.
module bakery_ticket_arbiter (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [bta_pkg::IN_BYTES_W-1:0]     s_tdata,  // client
	input  logic                               s_tuser,  // action
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// grant_valid, grant_client, assigned_ticket, status, zero fill
	output logic [bta_pkg::OUT_BYTES_W-1:0]    m_tdata,
	input  logic                               cfg_we,
	input  logic [bta_pkg::CFG_BITS-1:0]       cfg_wdata
);
	import bta_pkg::*;

	state_t                 state_q, state_d;
	logic [CFG_BITS-1:0]    active_q;
	logic [CNT_BITS-1:0]    eff;
	logic                   action_q;
	scan_t                  chain [NUM_CLIENTS+1];
	scan_t                  final_q;
	wr_t                    wr;
	logic                   accept;
	logic                   load_out;
	logic                   out_vld_q;
	logic [OUT_BYTES_W-1:0] out_data_q;

	logic                   cli_active;
	logic [TICKET_BITS-1:0] new_t;
	logic [STATUS_W-1:0]    status;
	logic [TICKET_BITS-1:0] cand;
	logic                   g_vld;
	logic [CLIENT_W-1:0]    g_cli;
	logic [ASSIGNED_W-1:0]  assigned;
	logic [OUT_W-1:0]       packed_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= CFG_BITS'(8);
		end else if (cfg_we) begin
			active_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (active_q == '0) begin
			eff = CNT_BITS'(1);
		end else if (32'(active_q) > NUM_CLIENTS) begin
			eff = CNT_BITS'(NUM_CLIENTS);
		end else begin
			eff = CNT_BITS'(active_q);
		end
	end

	assign accept = s_tvalid && s_tready;

	always_comb begin
		chain[0]          = '0;
		chain[0].vld      = accept;
		chain[0].client   = s_tdata[CLIENT_W-1:0];
	end

	for (genvar k = 0; k < NUM_CLIENTS; k++) begin : g_cell
		bta_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.idx    (IDX_BITS'(k)),
			.count  (eff),
			.rin    (chain[k]),
			.wr     (wr),
			.rout   (chain[k+1])
		);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= s_tuser;
		end
		if (chain[NUM_CLIENTS].vld) begin
			final_q <= chain[NUM_CLIENTS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		load_out = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (chain[NUM_CLIENTS].vld) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_vld_q || m_tready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Outcome of the event, from the finished scan record.
	always_comb begin
		cli_active = 32'(final_q.client) < 32'(eff);
		new_t      = final_q.own_t;
		status     = ST_OK;
		wr.en      = 1'b0;
		wr.idx     = IDX_BITS'(final_q.client);
		wr.value   = '0;
		if (cli_active) begin
			if (action_q == ACT_REQUEST) begin
				if (final_q.own_t != '0) begin
					status = ST_REDUNDANT;
				end else if (final_q.top == TICKET_MAX) begin
					new_t  = TICKET_MAX;
					status = ST_SATURATED;
					wr.en  = load_out;
				end else begin
					new_t  = TICKET_BITS'(final_q.top + 1'b1);
					wr.en  = load_out;
				end
			end else begin
				if (final_q.own_t == '0) begin
					status = ST_NO_TICKET;
				end
				new_t = '0;
				wr.en = load_out;
			end
		end
		wr.value = new_t;
		cand     = cli_active ? new_t : '0;
		assigned = cli_active ? ASSIGNED_W'(new_t) : '0;

		// The issuing client was kept out of the chain search; weigh it now.
		if (cand != '0 && (!final_q.best_vld || cand < final_q.best_t ||
				(cand == final_q.best_t && 32'(final_q.client) < 32'(final_q.best_idx)))) begin
			g_vld = 1'b1;
			g_cli = final_q.client;
		end else if (final_q.best_vld) begin
			g_vld = 1'b1;
			g_cli = CLIENT_W'(final_q.best_idx);
		end else begin
			g_vld = 1'b0;
			g_cli = '0;
		end
		packed_out = {status, assigned, g_cli, g_vld};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load_out) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= OUT_BYTES_W'(packed_out);
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

endmodule

[sim/tb_bakery_ticket_arbiter.sv]
// Self-checking testbench for bakery_ticket_arbiter: lock events stream in, and
// each grant report is checked against a ticket-book predictor kept here.
// Depends on bta_pkg and the arbiter RTL.
module tb_bakery_ticket_arbiter;
	import bta_pkg::*;

	localparam int CLK_PERIOD = 12;

	typedef struct packed {
		logic                action;
		logic [CLIENT_W-1:0] client;
	} lock_event_t;

	// Packed with the last report field first so that a cast of m_tdata lines up.
	typedef struct packed {
		logic [STATUS_W-1:0]   status;
		logic [ASSIGNED_W-1:0] assigned;
		logic [CLIENT_W-1:0]   grant_client;
		logic                  grant_valid;
	} grant_report_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_BYTES_W-1:0]  s_tdata = '0;   // client, zero fill
	logic                   s_tuser = 1'b0; // action
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_BYTES_W-1:0] m_tdata;        // grant_valid, grant_client, assigned_ticket, status
	logic                   cfg_we = 1'b0;
	logic [CFG_BITS-1:0]    cfg_wdata = '0;

	bakery_ticket_arbiter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#(CLK_PERIOD / 2) clk = 1'b1;
		#(CLK_PERIOD / 2) clk = 1'b0;
	end

	// Predictor state: the ticket book and the active client register.
	logic [TICKET_BITS-1:0] ticket_book [NUM_CLIENTS];
	logic [CFG_BITS-1:0]    active_reg;

	lock_event_t   lock_events[$];
	grant_report_t grant_reports_due[$];
	lock_event_t   event_on_bus;
	bit            event_held = 1'b0;
	bit            idling_on = 1'b1;
	int            send_gap = 0;
	int            stall_left = 0;
	int            mismatch_count = 0;

	function automatic int scan_count();
		if (active_reg == 0)
			return 1;
		if (active_reg > NUM_CLIENTS)
			return NUM_CLIENTS;
		return int'(active_reg);
	endfunction

	function automatic grant_report_t predict_grant(lock_event_t ev);
		grant_report_t          r;
		int                     n;
		logic [TICKET_BITS-1:0] top;
		logic [TICKET_BITS-1:0] best;
		r = '0;
		n = scan_count();
		top = '0;
		best = '0;
		if (ev.client < n) begin
			if (ev.action == ACT_REQUEST) begin
				if (ticket_book[ev.client] != 0) begin
					r.status = ST_REDUNDANT;
				end else begin
					for (int k = 0; k < n; k++)
						if (ticket_book[k] > top)
							top = ticket_book[k];
					if (top == TICKET_MAX) begin
						ticket_book[ev.client] = TICKET_MAX;
						r.status = ST_SATURATED;
					end else begin
						ticket_book[ev.client] = top + 1'b1;
					end
				end
				r.assigned = ticket_book[ev.client];
			end else begin
				if (ticket_book[ev.client] == 0)
					r.status = ST_NO_TICKET;
				ticket_book[ev.client] = '0;
			end
		end
		// Smallest nonzero ticket wins; a strict compare keeps ties at the lower index.
		for (int k = 0; k < n; k++) begin
			if (ticket_book[k] != 0 && (!r.grant_valid || ticket_book[k] < best)) begin
				r.grant_valid = 1'b1;
				r.grant_client = CLIENT_W'(k);
				best = ticket_book[k];
			end
		end
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idling_on || r < 45)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	// Event driver: one transfer at a time, with random gaps between them.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				grant_reports_due.push_back(predict_grant(event_on_bus));
				event_held = 1'b0;
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (lock_events.size() != 0) begin
					event_on_bus = lock_events.pop_front();
					event_held = 1'b1;
					s_tdata <= IN_BYTES_W'(event_on_bus.client);
					s_tuser <= event_on_bus.action;
					s_tvalid <= 1'b1;
					send_gap = pick_gap();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Report monitor with random back-pressure.
	always @(posedge clk) begin
		grant_report_t got, want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = grant_report_t'(m_tdata[OUT_W-1:0]);
				if (grant_reports_due.size() == 0) begin
					$error("grant report with no event outstanding: %h", m_tdata);
					mismatch_count++;
				end else begin
					want = grant_reports_due.pop_front();
					check_field("grant_valid", int'(want.grant_valid), int'(got.grant_valid));
					check_field("grant_client", int'(want.grant_client),
						int'(got.grant_client));
					check_field("assigned_ticket", int'(want.assigned), int'(got.assigned));
					check_field("status", int'(want.status), int'(got.status));
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	task automatic push_event(input logic action, input int client);
		lock_events.push_back('{action: action, client: CLIENT_W'(client)});
	endtask

	// Holds the sender back until every report is in and the scan has settled.
	task automatic drain();
		while (lock_events.size() != 0 || event_held || grant_reports_due.size() != 0)
			@(posedge clk);
		repeat (NUM_CLIENTS + 4) @(posedge clk);
	endtask

	task automatic write_active(input logic [CFG_BITS-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		active_reg = value;
	endtask

	initial begin
		int n;
		int sel;
		for (int k = 0; k < NUM_CLIENTS; k++)
			ticket_book[k] = '0;
		active_reg = 4'd8;
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Directed: first tickets, redundant request, release without a ticket.
		write_active(4'd8);
		push_event(ACT_RELEASE, 0);
		push_event(ACT_REQUEST, 7);
		push_event(ACT_REQUEST, 0);
		push_event(ACT_REQUEST, 0);
		push_event(ACT_REQUEST, 3);
		push_event(ACT_RELEASE, 7);
		push_event(ACT_RELEASE, 7);
		push_event(ACT_REQUEST, 7);
		push_event(ACT_REQUEST, 5);
		drain();
		// Fewer active clients: events from the others are ignored, their tickets kept.
		write_active(4'd3);
		push_event(ACT_REQUEST, 7);
		push_event(ACT_RELEASE, 5);
		push_event(ACT_REQUEST, 1);
		push_event(ACT_RELEASE, 0);
		drain();
		// A count of zero behaves as one.
		write_active(4'd0);
		push_event(ACT_REQUEST, 1);
		push_event(ACT_RELEASE, 0);
		push_event(ACT_REQUEST, 0);
		drain();
		// A count above the client total behaves as the total.
		write_active(4'd15);
		push_event(ACT_RELEASE, 0);
		push_event(ACT_RELEASE, 1);
		push_event(ACT_RELEASE, 3);
		push_event(ACT_RELEASE, 5);
		push_event(ACT_RELEASE, 7);
		drain();

		// Random batches, each with its own active count and idling mode.
		for (int b = 0; b < 15; b++) begin
			sel = $urandom_range(0, 9);
			if (sel == 0)
				write_active(4'd1);
			else if (sel == 1)
				write_active(4'd8);
			else
				write_active(CFG_BITS'($urandom_range(0, 15)));
			idling_on = ($urandom_range(0, 3) != 0);
			n = scan_count();
			for (int i = 0; i < 100; i++) begin
				push_event(($urandom_range(0, 99) < 55) ? ACT_REQUEST : ACT_RELEASE,
					($urandom_range(0, 9) < 8) ? $urandom_range(0, n - 1)
						: $urandom_range(0, NUM_CLIENTS - 1));
			end
			drain();
		end

		// All clients back in the scan, then clear out.
		idling_on = 1'b1;
		write_active(4'd8);
		for (int c = 2; c < NUM_CLIENTS; c++)
			push_event(ACT_REQUEST, c);
		for (int c = 0; c < NUM_CLIENTS; c++)
			push_event(ACT_RELEASE, c);
		push_event(ACT_REQUEST, 4);
		drain();

		if (mismatch_count == 0)
			$display("tb_bakery_ticket_arbiter OK");
		else
			$display("tb_bakery_ticket_arbiter NOT OK");
		$finish;
	end

	initial begin
		#(CLK_PERIOD * 8_000_000);
		$display("tb_bakery_ticket_arbiter NOT OK");
		$finish;
	end

endmodule
